FILE: hw/rtl/vfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vision frame parser package
// Shared sizes, constants and register map of the vision frame parser.
// ----------------------------------------------------------------------------
package vfp_pkg;

    // Depth of the frame store and width of the position counter.
    localparam int FRAME_DEPTH = 10;
    localparam int COUNT_W     = $clog2(FRAME_DEPTH + 1);

    // Only store positions 1 to 6 are ever decoded, so only they are kept.
    localparam int DEC_FIRST   = 1;
    localparam int DEC_BYTES   = 6;
    localparam int DEC_IDX_W   = $clog2(DEC_BYTES);

    // Fixed-point decode constants: full scale is 100 in Q8.
    localparam int MAG_W       = 15;
    localparam int VALUE_W     = 16;
    localparam int PROD_W      = 30;
    localparam int FULL_SCALE  = 25600;
    localparam int DIVISOR     = 32767;
    localparam int HALF_DIV    = 16383;

    // Marker reset values.
    localparam logic [7:0] START_MARKER_RST = 8'h73;
    localparam logic [7:0] END_MARKER_RST   = 8'h65;

    // Configuration register map, selected by address bit 2.
    localparam int ADDR_W = 3;
    typedef enum logic {
        REG_START_MARKER = 1'b0,
        REG_END_MARKER   = 1'b1
    } reg_idx_t;

    typedef logic [7:0] byte_t;

endpackage : vfp_pkg
`default_nettype wire

FILE: hw/rtl/vision_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vision frame parser
// Byte-serial frame parser that decodes yaw, pitch and distance.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle unless the input is
// stalled. When idle, a byte equal to start_marker opens a frame; inside a
// frame every byte is counted into the store (the count saturates at the
// store depth), and a byte equal to end_marker closes it and produces one
// request carrying yaw, pitch and distance decoded from store bytes 1-2,
// 3-4 and 5-6 as signed Q8 values. A closing byte's store bytes are
// captured in the decode register at the accepting edge, and the decoded
// values load the output register when that register is empty or being
// taken. The input is stalled only when both of these registers are full
// and the output is stalled, so a byte is taken in every cycle while
// results are drained.
// The store resets to zero, so a frame that closes early decodes stale or
// zero bytes.
// ----------------------------------------------------------------------------
module vision_frame_parser
    import vfp_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,

    // Received byte channel.
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire byte_t                 rx_byte,

    // Decoded result channel.
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic signed [VALUE_W-1:0]  yaw_value,
    output logic signed [VALUE_W-1:0]  pitch_value,
    output logic signed [VALUE_W-1:0]  distance_value,

    // Configuration port.
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [ADDR_W-1:0]           paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // Configuration registers.
    byte_t start_marker_reg, start_marker_next;
    byte_t end_marker_reg,   end_marker_next;

    // Parser state.
    logic               in_frame_reg,   in_frame_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    byte_t              store_reg [DEC_BYTES];
    byte_t              store_next [DEC_BYTES];

    // Decode register and output register.
    logic  dec_valid_reg, dec_valid_next;
    byte_t dec_bytes_reg [DEC_BYTES];
    byte_t dec_bytes_next [DEC_BYTES];
    logic  out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] yaw_reg,  yaw_next;
    logic signed [VALUE_W-1:0] pitch_reg, pitch_next;
    logic signed [VALUE_W-1:0] dist_reg,  dist_next;

    logic                      in_accept;
    logic                      closing;
    logic                      dec_advance;
    logic                      cfg_write;
    reg_idx_t                  cfg_idx;
    logic [DEC_IDX_W-1:0]      store_idx;
    logic signed [VALUE_W-1:0] yaw_dec;
    logic signed [VALUE_W-1:0] pitch_dec;
    logic signed [VALUE_W-1:0] dist_dec;

    // Configuration access; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        prdata            = 32'd0;
        unique case (cfg_idx)
            REG_START_MARKER:
            begin
                prdata = {24'd0, start_marker_reg};
                if (cfg_write)
                begin
                    start_marker_next = pwdata[7:0];
                end
            end
            REG_END_MARKER:
            begin
                prdata = {24'd0, end_marker_reg};
                if (cfg_write)
                begin
                    end_marker_next = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    // Pipeline flow: the decode register moves on whenever the output
    // register is empty or being taken.
    assign dec_advance = dec_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = dec_valid_reg && !dec_advance;
    assign in_accept   = in_valid && !in_stall;
    assign closing     = in_accept && in_frame_reg && (rx_byte == end_marker_reg);
    assign store_idx   = DEC_IDX_W'(byte_count_reg - COUNT_W'(DEC_FIRST));

    // Frame tracking and store update. The closing byte itself is stored
    // before the decode bytes are captured.
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        store_next      = store_reg;
        if (in_accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == start_marker_reg)
                begin
                    in_frame_next   = 1'b1;
                    byte_count_next = COUNT_W'(1);
                end
            end
            else
            begin
                if (byte_count_reg < COUNT_W'(FRAME_DEPTH))
                begin
                    byte_count_next = byte_count_reg + COUNT_W'(1);
                    if (byte_count_reg >= COUNT_W'(DEC_FIRST) &&
                        byte_count_reg < COUNT_W'(DEC_FIRST + DEC_BYTES))
                    begin
                        store_next[store_idx] = rx_byte;
                    end
                end
                if (rx_byte == end_marker_reg)
                begin
                    in_frame_next   = 1'b0;
                    byte_count_next = '0;
                end
            end
        end
    end

    // Decode register capture.
    always_comb
    begin
        dec_valid_next = dec_valid_reg;
        dec_bytes_next = dec_bytes_reg;
        if (closing)
        begin
            dec_valid_next = 1'b1;
            dec_bytes_next = store_next;
        end
        else if (dec_advance)
        begin
            dec_valid_next = 1'b0;
        end
    end

    // Pair decoders between the decode register and the output register.
    vfp_pair_decode u_yaw_dec
    (
        .hi    (dec_bytes_reg[0]),
        .lo    (dec_bytes_reg[1]),
        .value (yaw_dec)
    );

    vfp_pair_decode u_pitch_dec
    (
        .hi    (dec_bytes_reg[2]),
        .lo    (dec_bytes_reg[3]),
        .value (pitch_dec)
    );

    vfp_pair_decode u_dist_dec
    (
        .hi    (dec_bytes_reg[4]),
        .lo    (dec_bytes_reg[5]),
        .value (dist_dec)
    );

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        yaw_next       = yaw_reg;
        pitch_next     = pitch_reg;
        dist_next      = dist_reg;
        if (dec_advance)
        begin
            out_valid_next = 1'b1;
            yaw_next       = yaw_dec;
            pitch_next     = pitch_dec;
            dist_next      = dist_dec;
        end
    end

    assign out_valid      = out_valid_reg;
    assign yaw_value      = yaw_reg;
    assign pitch_value    = pitch_reg;
    assign distance_value = dist_reg;

    // Control state and store, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            in_frame_reg     <= 1'b0;
            byte_count_reg   <= '0;
            store_reg        <= '{default: 8'd0};
            dec_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
            in_frame_reg     <= in_frame_next;
            byte_count_reg   <= byte_count_next;
            store_reg        <= store_next;
            dec_valid_reg    <= dec_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dec_bytes_reg <= dec_bytes_next;
        yaw_reg       <= yaw_next;
        pitch_reg     <= pitch_next;
        dist_reg      <= dist_next;
    end

    // The position counter never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_W'(FRAME_DEPTH))
        else $error("byte count beyond store depth");

    // An idle parser holds no count.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> byte_count_reg == '0)
        else $error("nonzero byte count while idle");

    // A closing byte always reaches the decode register and ends the frame.
    a_close_capture: assert property (@(posedge clk) disable iff (!rst_n)
        closing |=> dec_valid_reg && !in_frame_reg)
        else $error("closing byte not captured");

    // The decoded yaw value stays within plus or minus full scale.
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (yaw_reg <= VALUE_W'(FULL_SCALE)) &&
                          (yaw_reg >= -VALUE_W'(FULL_SCALE)))
        else $error("yaw out of range");

endmodule : vision_frame_parser
`default_nettype wire

FILE: hw/rtl/vfp_pair_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vision frame parser pair decoder
// Turns one big-endian byte pair into a signed Q8 value in -100..100.
// ----------------------------------------------------------------------------
module vfp_pair_decode
    import vfp_pkg::*;
(
    input  wire byte_t                     hi,
    input  wire byte_t                     lo,
    output logic signed [VALUE_W-1:0]      value
);

    logic [MAG_W-1:0]   mag;
    logic [PROD_W-1:0]  num;
    logic [MAG_W-1:0]   quot_hi;
    logic [MAG_W:0]     rem;
    logic [MAG_W:0]     quot;
    logic [VALUE_W-1:0] scaled;

    // Numerator mag * 25600 plus half the divisor for round to nearest.
    assign mag = {hi[6:0], lo};
    assign num = PROD_W'(mag) * PROD_W'(FULL_SCALE) + PROD_W'(HALF_DIV);

    // Divide by 32767 as a divide by 32768 plus a correction: since
    // q0 * 32768 = q0 * 32767 + q0, the remainder is the low bits plus q0,
    // which stays at or below twice the divisor.
    assign quot_hi = num[PROD_W-1:MAG_W];
    assign rem     = {1'b0, num[MAG_W-1:0]} + {1'b0, quot_hi};

    always_comb
    begin
        if (rem >= (MAG_W+1)'(2 * DIVISOR))
        begin
            quot = {1'b0, quot_hi} + (MAG_W+1)'(2);
        end
        else if (rem >= (MAG_W+1)'(DIVISOR))
        begin
            quot = {1'b0, quot_hi} + (MAG_W+1)'(1);
        end
        else
        begin
            quot = {1'b0, quot_hi};
        end
    end

    // The top bit of the pair shifts the value down by full scale.
    assign scaled = hi[7] ? (VALUE_W'(quot) - VALUE_W'(FULL_SCALE)) : VALUE_W'(quot);
    assign value  = signed'(scaled);

endmodule : vfp_pair_decode
`default_nettype wire
